// ===== hdl/lpc_pkg.sv =====
// lpc_pkg: shared types and constants of the lidar point colorizer.
// Frame size, pipeline widths, queue sizes and the item and result records.
// Depends on nothing.
`default_nettype none
package lpc_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int PIX_COUNT    = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);
  localparam int MAX_DIM      = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  // quotient bits kept by the divider; anything larger is off the frame
  localparam int QW           = $clog2(MAX_DIM);
  localparam int DW           = 64 + QW;

  localparam int FQ_DEPTH  = 4;
  localparam int OUT_DEPTH = 32;
  localparam int OQ_CW     = $clog2(OUT_DEPTH + 1);

  localparam int NUM_REGS = 7;
  localparam int PADDR_W  = $clog2(8 * NUM_REGS);
  localparam logic signed [31:0] MIN_FWD_RESET = 32'sd16384;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MIN_FWD = 3'd0,
    REG_R0C01   = 3'd1,
    REG_R0C23   = 3'd2,
    REG_R1C01   = 3'd3,
    REG_R1C23   = 3'd4,
    REG_R2C01   = 3'd5,
    REG_R2C23   = 3'd6
  } reg_idx_t;

  // projection words [row][col], Q16.16
  typedef logic [2:0][3:0][31:0] proj_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       rgb;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
  } job_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [23:0] rgb;
  } result_t;

  typedef struct packed {
    logic push;
    logic release_slot;
  } back_status_t;

endpackage
`default_nettype wire

// ===== hdl/lpc_front.sv =====
// lpc_front: drops points under min_fwd and off-frame pixels, queues the rest.
// Depends on lpc_pkg.
`default_nettype none
module lpc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              cmd,
  input  wire logic [9:0]        col,
  input  wire logic [8:0]        row,
  input  wire logic [7:0]        red,
  input  wire logic [7:0]        green,
  input  wire logic [7:0]        blue,
  input  wire logic [31:0]       px,
  input  wire logic [31:0]       py,
  input  wire logic [31:0]       pz,
  input  wire logic signed [31:0] min_fwd,
  input  wire logic              take,
  output logic                   head_valid,
  output lpc_pkg::job_t          head
);
  import lpc_pkg::*;

  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

  job_t             q_mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CW-1:0] cnt_r;
  logic             keep, enq;
  job_t             job;

  always_comb begin
    job.cmd  = cmd_t'(cmd);
    job.addr = ADDR_W'(row) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(col);
    job.rgb  = {red, green, blue};
    job.x    = px;
    job.y    = py;
    job.z    = pz;
    if (job.cmd == CMD_POINT) begin
      keep = $signed(px) >= min_fwd;
    end else begin
      keep = (ADDR_W'(col) < ADDR_W'(IMAGE_WIDTH)) && (ADDR_W'(row) < ADDR_W'(IMAGE_HEIGHT));
    end
  end

  assign full       = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign enq        = push && !full && keep;
  assign head_valid = (cnt_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem_r[wr_ptr_r] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + FQ_AW'(1);
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + FQ_AW'(1);
      end
      cnt_r <= cnt_r + FQ_CW'(enq) - FQ_CW'(take);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lpc_back.sv =====
// lpc_back: projection multiply, row sums, pipelined division and image store.
// Depends on lpc_pkg.
`default_nettype none
module lpc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire lpc_pkg::job_t   in_job,
  input  wire lpc_pkg::proj_t  proj,
  output lpc_pkg::back_status_t status,
  output lpc_pkg::result_t     res
);
  import lpc_pkg::*;

  // multiply stage
  logic signed [31:0] coord [3];
  logic signed [63:0] prod [3][3];
  logic               st1_v_r;
  job_t               st1_job_r;
  logic signed [63:0] st1_p_r [3][3];
  // partial sums
  logic               st2_v_r;
  job_t               st2_job_r;
  logic signed [63:0] st2_a_r [3];
  logic signed [63:0] st2_b_r [3];
  // row sums
  logic               st3_v_r;
  job_t               st3_job_r;
  logic signed [63:0] st3_s_r [3];
  // divider prep
  logic [63:0]        mag0, mag1;
  logic               ovf0, ovf1;
  // divider stages
  logic               dv_v_r    [QW+1];
  job_t               dv_job_r  [QW+1];
  logic               dv_ok_r   [QW+1];
  logic               dv_neg0_r [QW+1];
  logic               dv_neg1_r [QW+1];
  logic [63:0]        dv_den_r  [QW+1];
  logic [63:0]        dv_rem0_r [QW+1];
  logic [63:0]        dv_rem1_r [QW+1];
  logic [QW-1:0]      dv_q0_r   [QW+1];
  logic [QW-1:0]      dv_q1_r   [QW+1];
  logic [DW-1:0]      sh [QW];
  logic               ge0 [QW];
  logic               ge1 [QW];
  // frame check and store
  logic [QW-1:0]      u, v;
  logic               ok_e;
  logic [ADDR_W-1:0]  addr_e;
  logic               e_v_r, e_ok_r;
  job_t               e_job_r;
  logic [ADDR_W-1:0]  e_addr_r;
  logic               m_v_r, m_ok_r;
  job_t               m_job_r;
  logic [23:0]        m_rgb_r;
  logic [23:0]        img_mem [PIX_COUNT];

  always_comb begin
    coord[0] = $signed(in_job.x);
    coord[1] = $signed(in_job.y);
    coord[2] = $signed(in_job.z);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed(proj[r][c]) * coord[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      st3_v_r <= 1'b0;
      e_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      for (int g = 0; g <= QW; g++) begin
        dv_v_r[g] <= 1'b0;
      end
    end else begin
      st1_v_r   <= in_valid;
      st2_v_r   <= st1_v_r;
      st3_v_r   <= st2_v_r;
      dv_v_r[0] <= st3_v_r;
      for (int g = 0; g < QW; g++) begin
        dv_v_r[g+1] <= dv_v_r[g];
      end
      e_v_r <= dv_v_r[QW];
      m_v_r <= e_v_r;
    end
  end

  // floor division by 4 is an arithmetic shift; column 3 enters as word * 2^14
  always_ff @(posedge clk) begin
    st1_job_r <= in_job;
    st1_p_r   <= prod;
    st2_job_r <= st1_job_r;
    st3_job_r <= st2_job_r;
    for (int r = 0; r < 3; r++) begin
      st2_a_r[r] <= (st1_p_r[r][0] >>> 2) + (st1_p_r[r][1] >>> 2);
      st2_b_r[r] <= (st1_p_r[r][2] >>> 2)
                    + $signed({{18{proj[r][3][31]}}, proj[r][3], 14'b0});
      st3_s_r[r] <= st2_a_r[r] + st2_b_r[r];
    end
  end

  always_comb begin
    mag0 = st3_s_r[0][63] ? 64'(-st3_s_r[0]) : 64'(st3_s_r[0]);
    mag1 = st3_s_r[1][63] ? 64'(-st3_s_r[1]) : 64'(st3_s_r[1]);
    ovf0 = DW'(mag0) >= (DW'(st3_s_r[2]) << QW);
    ovf1 = DW'(mag1) >= (DW'(st3_s_r[2]) << QW);
    for (int g = 0; g < QW; g++) begin
      sh[g]  = DW'(dv_den_r[g]) << (QW - 1 - g);
      ge0[g] = DW'(dv_rem0_r[g]) >= sh[g];
      ge1[g] = DW'(dv_rem1_r[g]) >= sh[g];
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  always_ff @(posedge clk) begin
    dv_job_r[0]  <= st3_job_r;
    dv_ok_r[0]   <= (st3_s_r[2] > 64'sd0) && !ovf0 && !ovf1;
    dv_neg0_r[0] <= st3_s_r[0][63];
    dv_neg1_r[0] <= st3_s_r[1][63];
    dv_den_r[0]  <= 64'(st3_s_r[2]);
    dv_rem0_r[0] <= mag0;
    dv_rem1_r[0] <= mag1;
    dv_q0_r[0]   <= '0;
    dv_q1_r[0]   <= '0;
    for (int g = 0; g < QW; g++) begin
      dv_job_r[g+1]  <= dv_job_r[g];
      dv_ok_r[g+1]   <= dv_ok_r[g];
      dv_neg0_r[g+1] <= dv_neg0_r[g];
      dv_neg1_r[g+1] <= dv_neg1_r[g];
      dv_den_r[g+1]  <= dv_den_r[g];
      dv_rem0_r[g+1] <= ge0[g] ? dv_rem0_r[g] - sh[g][63:0] : dv_rem0_r[g];
      dv_rem1_r[g+1] <= ge1[g] ? dv_rem1_r[g] - sh[g][63:0] : dv_rem1_r[g];
      dv_q0_r[g+1]   <= {dv_q0_r[g][QW-2:0], ge0[g]};
      dv_q1_r[g+1]   <= {dv_q1_r[g][QW-2:0], ge1[g]};
    end
  end

  // a negative sum truncates to zero only when its quotient magnitude is zero
  always_comb begin
    u    = dv_q0_r[QW];
    v    = dv_q1_r[QW];
    ok_e = (dv_job_r[QW].cmd == CMD_POINT) && dv_ok_r[QW]
           && !(dv_neg0_r[QW] && (u != '0)) && !(dv_neg1_r[QW] && (v != '0))
           && ({1'b0, u} < (QW+1)'(IMAGE_WIDTH)) && ({1'b0, v} < (QW+1)'(IMAGE_HEIGHT));
    if (dv_job_r[QW].cmd == CMD_POINT) begin
      addr_e = ADDR_W'(v) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(u);
    end else begin
      addr_e = dv_job_r[QW].addr;
    end
  end

  always_ff @(posedge clk) begin
    e_job_r  <= dv_job_r[QW];
    e_ok_r   <= ok_e;
    e_addr_r <= addr_e;
    m_job_r  <= e_job_r;
    m_ok_r   <= e_ok_r;
  end

  always_ff @(posedge clk) begin
    if (e_v_r && (e_job_r.cmd == CMD_PIXEL)) begin
      img_mem[e_addr_r] <= e_job_r.rgb;
    end
    m_rgb_r <= img_mem[e_addr_r];
  end

  assign status.push         = m_v_r && (m_job_r.cmd == CMD_POINT) && m_ok_r;
  assign status.release_slot = m_v_r && (m_job_r.cmd == CMD_POINT) && !m_ok_r;
  assign res.x   = m_job_r.x;
  assign res.y   = m_job_r.y;
  assign res.z   = m_job_r.z;
  assign res.rgb = m_rgb_r;

endmodule
`default_nettype wire

// ===== hdl/lpc_outq.sv =====
// lpc_outq: result queue in front of the consumer.
// Depends on lpc_pkg.
`default_nettype none
module lpc_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire lpc_pkg::result_t wr_data,
  input  wire logic             rd_en,
  output logic                  empty,
  output lpc_pkg::result_t      rd_data
);
  import lpc_pkg::*;

  localparam int OQ_AW = $clog2(OUT_DEPTH);

  result_t          mem_r [OUT_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;

  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      cnt_r <= cnt_r + OQ_CW'(wr_en) - OQ_CW'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lidar_point_colorizer_core.sv =====
// Lidar point colorizer: colors lidar points with pixels of a stored camera frame.
// Top level; depends on lpc_pkg, lpc_front, lpc_back and lpc_outq.
//
// Usage:
//   Input channel (push/full, in_*): command 0 writes one pixel into the image
//   store, command 1 projects one point. Write the whole frame before pushing
//   points that read it. Results (empty/pop, out_*) show in order each point with
//   x >= threshold inside the frame at positive depth, with that pixel's color.
//   Configuration: APB-style, 64-bit data, register i at byte address 8*i;
//   write only while the block is idle. pready is tied high.
// Throughput: one item per cycle, limited by the single image store port that
//   pixel writes and point reads share; a point waits for a free result slot.
// Pipeline: the multiply, two add stages, divider prep, QW divider stages,
//   frame check and the store read, in that order.
// Stall: results wait in a 32-entry queue; a point is issued to the pipeline
//   only against a free queue slot, so a stalled receiver fills the queue,
//   then the 4-entry front queue, then full rises.
// Reset: synchronous, active low; empties both queues, loads the threshold
//   with 0.25 m and the projection with zero. The image store is not cleared.
`default_nettype none
module lidar_point_colorizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_command,
  input  wire logic [9:0]  in_pixel_col,
  input  wire logic [8:0]  in_pixel_row,
  input  wire logic [7:0]  in_pixel_red,
  input  wire logic [7:0]  in_pixel_green,
  input  wire logic [7:0]  in_pixel_blue,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [lpc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import lpc_pkg::*;

  logic signed [31:0] min_fwd_r;
  proj_t              proj_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  logic               head_valid, take, issue, pop_ok;
  job_t               head;
  back_status_t       bstat;
  result_t            bres, ores;
  logic [OQ_CW-1:0]   cred_r, cred_nxt;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_fwd_r <= MIN_FWD_RESET;
      proj_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_FWD: min_fwd_r <= $signed(pwdata[31:0]);
        REG_R0C01:   proj_r[0][1:0] <= pwdata;
        REG_R0C23:   proj_r[0][3:2] <= pwdata;
        REG_R1C01:   proj_r[1][1:0] <= pwdata;
        REG_R1C23:   proj_r[1][3:2] <= pwdata;
        REG_R2C01:   proj_r[2][1:0] <= pwdata;
        REG_R2C23:   proj_r[2][3:2] <= pwdata;
        default: ;  // no register here; drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_FWD: prdata = {32'b0, min_fwd_r};
      REG_R0C01:   prdata = proj_r[0][1:0];
      REG_R0C23:   prdata = proj_r[0][3:2];
      REG_R1C01:   prdata = proj_r[1][1:0];
      REG_R1C23:   prdata = proj_r[1][3:2];
      REG_R2C01:   prdata = proj_r[2][1:0];
      REG_R2C23:   prdata = proj_r[2][3:2];
      default:     prdata = '0;
    endcase
  end

  // ---- front: classify and queue ----
  lpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .cmd        (in_command),
    .col        (in_pixel_col),
    .row        (in_pixel_row),
    .red        (in_pixel_red),
    .green      (in_pixel_green),
    .blue       (in_pixel_blue),
    .px         (in_point_x),
    .py         (in_point_y),
    .pz         (in_point_z),
    .min_fwd    (min_fwd_r),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  // Issue a pixel write freely; issue a point only when a result slot is
  // reserved for it. A dropped point hands its slot back at the end of the pipe.
  assign take     = head_valid && ((head.cmd == CMD_PIXEL) || (cred_r != '0));
  assign issue    = take && (head.cmd == CMD_POINT);
  assign pop_ok   = pop && !empty;
  assign cred_nxt = cred_r + OQ_CW'(bstat.release_slot) + OQ_CW'(pop_ok) - OQ_CW'(issue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= OQ_CW'(OUT_DEPTH);
    end else begin
      cred_r <= cred_nxt;
    end
  end

  // ---- back: project, divide, look up color ----
  lpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (take),
    .in_job   (head),
    .proj     (proj_r),
    .status   (bstat),
    .res      (bres)
  );

  // ---- result queue ----
  lpc_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bstat.push),
    .wr_data (bres),
    .rd_en   (pop_ok),
    .empty   (empty),
    .rd_data (ores)
  );

  assign out_x     = $signed(ores.x);
  assign out_y     = $signed(ores.y);
  assign out_z     = $signed(ores.z);
  assign out_red   = ores.rgb[23:16];
  assign out_green = ores.rgb[15:8];
  assign out_blue  = ores.rgb[7:0];

endmodule
`default_nettype wire

// ===== hdl/lpc_checker.sv =====
// lpc_checker: port-level checks of lidar_point_colorizer_core, bound to the top.
// Depends on lpc_pkg and the top level's ports.
`default_nettype none
module lpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] out_x,
  input wire logic [7:0]  out_red,
  input wire logic        pready
);
  import lpc_pkg::*;

  // no result can come out of reset and the pipe straight away
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty ##1 empty) else $error("result present right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !full) else $error("input queue full right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_x) && $stable(out_red)))
    else $error("waiting result changed before transfer");

  a_cfg_ready: assert property (@(posedge clk)
    $past(rst_n) |-> pready) else $error("configuration port not ready");

endmodule

bind lidar_point_colorizer_core lpc_checker u_lpc_checker (.*);
`default_nettype wire
